// File: rtl/pirl_pkg.sv
// Package with the command codes, field widths and shared types of the positional list.
package pirl_pkg;

    // Field widths fixed by the word format.
    localparam int CMD_W  = 2;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;
    localparam int CAP_W  = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Configuration register indexes and reset values.
    localparam int              REG_CAPACITY   = 0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // APB port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic execute;
    } pirl_cmd_t;

endpackage

// File: rtl/pirl_req_if.sv
// Request channel interface: command, position and value words.
interface pirl_req_if
    import pirl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

// File: rtl/pirl_rsp_if.sv
// Response channel interface: status, read data and list length words.
interface pirl_rsp_if
    import pirl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         length;

    modport source (output valid, output ok, output read_value, output length,
                    input ready);
    modport sink   (input valid, input ok, input read_value, input length,
                    output ready);
endinterface

// File: rtl/positional_insert_remove_list_top.sv
// Top level of the positional insert/remove list.
//
//   channel   direction  words / handshake
//   req_ch    sink       command, position, value; valid/ready
//   rsp_ch    source     ok, read_value, length; valid/ready
//   APB       slave      capacity register at byte address 0
//
// Every command's word sits in the result register the next cycle after it is taken,
// and a new command is taken each cycle while that register drains.
// All cells shift in parallel, so throughput is one word per cycle while responses are taken.
// Reset empties the list and sets capacity to 16; cell contents are not cleared.
// A stalled response holds its word and stops new commands only while it is held.
module positional_insert_remove_list_top
    import pirl_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    pirl_req_if.sink           req_ch,
    pirl_rsp_if.source         rsp_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CAP_W-1:0] capacity;
    pirl_cmd_t        cmd;

    // Configuration registers.
    pirl_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // Handshake control.
    pirl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .rsp_valid (rsp_ch.valid),
        .rsp_ready (rsp_ch.ready),
        .cmd       (cmd)
    );

    // List storage and result.
    pirl_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .capacity   (capacity),
        .command    (req_ch.command),
        .position   (req_ch.position),
        .value      (req_ch.value),
        .ok         (rsp_ch.ok),
        .read_value (rsp_ch.read_value),
        .length     (rsp_ch.length)
    );

endmodule

// File: rtl/pirl_cfg.sv
// APB register block holding the capacity register.
module pirl_cfg
    import pirl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [CAP_W-1:0]   capacity
);

    logic [CAP_W-1:0] capacity_reg;
    logic             sel_capacity;

    // Register index is the word address.
    assign sel_capacity = (paddr[PADDR_W-1:2] == 1'(REG_CAPACITY));
    assign pready       = 1'b1;

    // Capacity register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && sel_capacity)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Read back.
    assign prdata   = sel_capacity ? {{(PDATA_W-CAP_W){1'b0}}, capacity_reg} : '0;
    assign capacity = capacity_reg;

endmodule

// File: rtl/pirl_ctrl.sv
// Controller that tracks the output register and issues execute commands.
module pirl_ctrl
    import pirl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output pirl_cmd_t cmd
);

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic execute;

    // A new word is taken whenever the result slot is free or being drained.
    assign req_ready   = (state_reg == ST_EMPTY) || rsp_ready;
    assign execute     = req_valid && req_ready;
    assign cmd.execute = execute;
    assign rsp_valid   = (state_reg == ST_FULL);

    // Next state of the result slot.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (execute)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (!execute && rsp_ready)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/pirl_dp.sv
// Datapath with the shifting entry cells, the length counter and the result register.
module pirl_dp
    import pirl_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pirl_cmd_t                cmd,
    input  logic [CAP_W-1:0]         capacity,
    input  logic [CMD_W-1:0]         command,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     ok,
    output logic signed [DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]         length
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    logic [DATA_W-1:0]         cell_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          eff_cap;
    logic                      ins_ok;
    logic                      rem_ok;
    logic                      rd_ok;
    logic [IDX_W-1:0]          rd_idx;
    logic [DATA_W-1:0]         rd_data;
    logic                      ok_reg;
    logic signed [DATA_W-1:0]  read_value_reg;
    logic [CNT_W-1:0]          length_reg;

    // A capacity above the cell count acts as the cell count.
    assign eff_cap = (int'(capacity) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : capacity;

    // Bounds checks for each command.
    assign ins_ok = (command == CMD_INSERT) && (count_reg < eff_cap)
                    && (position <= count_reg);
    assign rem_ok = (command == CMD_REMOVE) && (position < count_reg);
    assign rd_ok  = (command == CMD_READ) && (position < count_reg);

    // Length after the command.
    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rem_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    // Entry cells: the cells from the position to the end of the list move together.
    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        logic [DATA_W-1:0] up_data;
        logic [DATA_W-1:0] down_data;
        logic              at_pos;
        logic              above_pos;
        logic              shift_up;
        logic              shift_down;

        if (k > 0)
        begin : g_up
            assign up_data = cell_reg[k-1];
        end
        else
        begin : g_up0
            assign up_data = value;
        end

        if (k < MAX_ENTRIES - 1)
        begin : g_down
            assign down_data = cell_reg[k+1];
        end
        else
        begin : g_down_last
            assign down_data = cell_reg[k];
        end

        assign at_pos     = (k == int'(position));
        assign above_pos  = (k > int'(position));
        assign shift_up   = ins_ok && above_pos && (k <= int'(count_reg));
        assign shift_down = rem_ok && (at_pos || above_pos) && (k + 1 < int'(count_reg));

        always_ff @(posedge clk)
        begin
            if (cmd.execute)
            begin
                if (ins_ok && at_pos)
                begin
                    cell_reg[k] <= value;
                end
                else if (shift_up)
                begin
                    cell_reg[k] <= up_data;
                end
                else if (shift_down)
                begin
                    cell_reg[k] <= down_data;
                end
            end
        end
    end

    // Read port; only a checked position is ever selected.
    assign rd_idx  = IDX_W'(position);
    assign rd_data = rd_ok ? cell_reg[rd_idx] : '0;

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            ok_reg         <= ins_ok || rem_ok || rd_ok;
            read_value_reg <= rd_data;
            length_reg     <= count_next;
        end
    end

    assign ok         = ok_reg;
    assign read_value = read_value_reg;
    assign length     = length_reg;

endmodule
